// ===== rtl/dsi_pkg.sv =====
// ----------------------------------------------------------------------------
// dsi_pkg
// Shared types and constants for the decimal string to scaled integer parser:
// parse phases, result status codes, the parse state record and its reset.
// ----------------------------------------------------------------------------
package dsi_pkg;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 4;
	localparam int VALUE_W = 31;
	localparam int SCALE_W = 30;
	localparam int COUNT_W = 4;
	localparam int STAT_W  = 2;
	localparam int OUT_W   = 72;   // 71 payload bits padded to whole bytes

	// Parse limits
	localparam int          MAX_DIGITS = 9;
	localparam logic [LEN_W-1:0] FREE_LIMIT = 4'd11;

	// Characters of interest
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_PARSE = 2'd1,
		PH_STOP  = 2'd2
	} phase_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_FIRST = 2'd1,
		ST_SHORT     = 2'd2,
		ST_NO_DIGITS = 2'd3
	} status_t;

	typedef struct packed {
		phase_t               phase;
		logic                 negative;
		logic                 point_seen;
		logic [VALUE_W-1:0]   magnitude;
		logic [SCALE_W-1:0]   scale_acc;
		logic [COUNT_W-1:0]   digits;
		logic [COUNT_W-1:0]   accepted;
		logic                 first_bad;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:      PH_FIRST,
		negative:   1'b0,
		point_seen: 1'b0,
		magnitude:  '0,
		scale_acc:  SCALE_W'(1),
		digits:     '0,
		accepted:   '0,
		first_bad:  1'b0
	};

endpackage

// ===== rtl/dsi_step.sv =====
// ----------------------------------------------------------------------------
// dsi_step
// Next parse state for one character: sign handling on the first byte, digit
// accumulation (x10 by shift and add), point tracking and stop conditions.
// ----------------------------------------------------------------------------
module dsi_step (
	input  dsi_pkg::parse_state_t        cur,
	input  logic [dsi_pkg::CHAR_W-1:0]   char_byte,
	input  logic [dsi_pkg::LEN_W-1:0]    field_length,
	output dsi_pkg::parse_state_t        nxt
);
	import dsi_pkg::*;

	logic               is_digit;
	logic [LEN_W-1:0]   limit;
	logic [COUNT_W-1:0] acc_base;
	logic [COUNT_W-1:0] dig_inc;
	logic [VALUE_W-1:0] mag_x10;
	logic [SCALE_W-1:0] scale_x10;

	assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
	assign limit     = (field_length == '0) ? FREE_LIMIT : field_length;
	assign mag_x10   = (cur.magnitude << 3) + (cur.magnitude << 1);
	assign scale_x10 = (cur.scale_acc << 3) + (cur.scale_acc << 1);
	assign dig_inc   = cur.digits + COUNT_W'(1);
	// first character skips the limit check since accepted is zero there
	assign acc_base  = cur.accepted;

	always_comb begin
		nxt = cur;
		case (cur.phase)
			PH_FIRST: begin
				if (char_byte == CH_MINUS) begin
					nxt.negative = 1'b1;
					nxt.accepted = COUNT_W'(1);
					nxt.phase    = PH_PARSE;
				end else if (char_byte == CH_PLUS) begin
					nxt.accepted = COUNT_W'(1);
					nxt.phase    = PH_PARSE;
				end else if (is_digit) begin
					// leading digit: accumulate right away
					nxt.magnitude = VALUE_W'(char_byte[3:0]);
					nxt.accepted  = acc_base + COUNT_W'(1);
					nxt.digits    = dig_inc;
					nxt.phase     = ({1'b0, dig_inc} >= 5'(MAX_DIGITS)) ? PH_STOP : PH_PARSE;
				end else begin
					nxt.first_bad = 1'b1;
					nxt.phase     = PH_STOP;
				end
			end
			PH_PARSE: begin
				if (cur.accepted >= limit || char_byte == CH_NUL) begin
					nxt.phase = PH_STOP;
				end else if (is_digit) begin
					nxt.magnitude = mag_x10 + VALUE_W'(char_byte[3:0]);
					nxt.accepted  = cur.accepted + COUNT_W'(1);
					nxt.digits    = dig_inc;
					if (cur.point_seen) begin
						nxt.scale_acc = scale_x10;
					end
					if ({1'b0, dig_inc} >= 5'(MAX_DIGITS)) begin
						nxt.phase = PH_STOP;
					end
				end else if (char_byte == CH_POINT && !cur.point_seen) begin
					nxt.point_seen = 1'b1;
					nxt.accepted   = cur.accepted + COUNT_W'(1);
				end else begin
					nxt.phase = PH_STOP;
				end
			end
			default: begin
				// stopped: ignore bytes until the last one
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== rtl/decimal_string_to_scaled_integer_core.sv =====
// ----------------------------------------------------------------------------
// decimal_string_to_scaled_integer_core
// Parses an ASCII decimal string, one byte per beat, into a signed scaled
// integer with counts and a status.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one character per beat in s_tdata[7:0]; s_tlast marks
//   the final byte of a string and triggers exactly one result beat.
//   Output stream m_*: one beat per string carrying value, scale, counts and
//   status. Non-last bytes produce no output beat.
//   cfg_we/cfg_wdata write field_length (0 = free length up to eleven); write
//   it only while no string is in flight.
//   Throughput: one byte per cycle, except while a last byte waits for a
//   blocked result. The byte is held in an input register, the parse update
//   and result formatting are one level of logic (x10 by shift and add) into
//   the parse state and the output register. The last byte passes the input
//   register, then its result beat is held in the output register.
//   Stall: while m_tready is low a pending result holds in the output
//   register; the input register and parse state keep moving for non-last
//   bytes and back-pressure s_tready only when a second result would collide.
//   Reset: arst_n clears the parse state, field_length and both valid flags.
// ----------------------------------------------------------------------------
module decimal_string_to_scaled_integer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [dsi_pkg::LEN_W-1:0]    cfg_wdata,   // field_length
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [dsi_pkg::CHAR_W-1:0]   s_tdata,     // char_byte
	input  logic                         s_tlast,     // last
	// output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [dsi_pkg::OUT_W-1:0]    m_tdata      // value[30:0], scale[60:31],
	                                                  // consumed_count[64:61],
	                                                  // digit_count[68:65],
	                                                  // status[70:69], zero[71]
);
	import dsi_pkg::*;

	logic [LEN_W-1:0]   field_length_q;

	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               last_s1;
	logic               adv_s1;

	parse_state_t       state_q;
	parse_state_t       state_nxt;

	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	status_t            status;
	logic [VALUE_W-1:0] value;
	logic [SCALE_W-1:0] scale;
	logic [COUNT_W-1:0] consumed;
	logic [COUNT_W-1:0] digit_cnt;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_length_q <= '0;
		end else if (cfg_we) begin
			field_length_q <= cfg_wdata;
		end
	end

	// Handshake: stage 1 moves unless it holds a last byte and the output is blocked
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Parse update
	dsi_step u_step (
		.cur          (state_q),
		.char_byte    (char_s1),
		.field_length (field_length_q),
		.nxt          (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_RESET;
		end else if (adv_s1) begin
			state_q <= last_s1 ? PARSE_RESET : state_nxt;
		end
	end

	// Result formatting from the updated state
	always_comb begin
		value     = '0;
		scale     = state_nxt.scale_acc;
		consumed  = state_nxt.accepted;
		digit_cnt = state_nxt.digits;
		if (state_nxt.first_bad) begin
			status    = ST_BAD_FIRST;
			scale     = SCALE_W'(1);
			consumed  = '0;
			digit_cnt = '0;
		end else if (state_nxt.accepted < field_length_q) begin
			status = ST_SHORT;
		end else if (state_nxt.digits == '0) begin
			status = ST_NO_DIGITS;
		end else begin
			status = ST_OK;
			value  = state_nxt.negative ? (VALUE_W'(0) - state_nxt.magnitude)
			                            : state_nxt.magnitude;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_data_q <= {1'b0, status, digit_cnt, consumed, scale, value};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
